/* rtl/core/dfi_pkg.sv */
// ----------------------------------------------------------------------------
// dfi_pkg: shared types and constants of the direct-form IIR filter
// Action, status and register codes, sequencer states, arithmetic widths.
// ----------------------------------------------------------------------------
package dfi_pkg;

  // highest filter order and depth of each history line
  localparam int MAX_ORDER  = 3;
  localparam int HIST_DEPTH = 3;

  // coefficient width and width of a coefficient sum (four terms, or unity plus three)
  localparam int COEF_W = 32;
  localparam int SUM_W  = 35;

  localparam int CFG_IDX_W = 3;

  // action codes
  localparam logic [1:0] ACT_STEP      = 2'd0;
  localparam logic [1:0] ACT_RESET_IN  = 2'd1;
  localparam logic [1:0] ACT_RESET_OUT = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INF_GAIN  = 2'd1;
  localparam logic [1:0] ST_ZERO_GAIN = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ORDER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COEF_0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COEF_1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COEF_2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COEF_3   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEN_COEF_1   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEN_COEF_2   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DEN_COEF_3   = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAC,
    S_MAC_TAIL,
    S_ROUND,
    S_SUM,
    S_CHECK,
    S_RMUL,
    S_DIVGO,
    S_DIV,
    S_RFILL,
    S_DONE
  } dfi_state_t;

  // divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } dfi_div_stat_t;

endpackage

/* rtl/core/dfi_div.sv */
// ----------------------------------------------------------------------------
// dfi_div: restoring unsigned divider
// One quotient bit per cycle; quotient and remainder hold after done.
// ----------------------------------------------------------------------------
module dfi_div import dfi_pkg::*; #(
  parameter int NUM_W = 59,
  parameter int DEN_W = 35
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NUM_W-1:0]   num,
  input  logic [DEN_W-1:0]   den,
  output dfi_div_stat_t      stat,
  output logic [NUM_W-1:0]   quo,
  output logic [DEN_W-1:0]   rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   den_ext;

  assign rem_sh  = {rem, quo[NUM_W-1]};
  assign den_ext = {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      quo   <= num;
      rem   <= '0;
    end else if (busy) begin
      if (rem_sh >= den_ext) begin
        rem <= DEN_W'(rem_sh - den_ext);
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

/* rtl/core/direct_form_iir_filter_top.sv */
// ----------------------------------------------------------------------------
// direct_form_iir_filter_top: direct-form I IIR filter, order 0 to 3
// Steps a signed sample through b/a coefficients in Q8.24 and presets the
// histories to steady state on request.
// ----------------------------------------------------------------------------
//
//  channel   handshake                beat carries
//  --------  -----------------------  ---------------------------------------
//  item      item_valid / item_stall  action, sample
//  result    result_valid / stall     filtered, status
//  config    cfg_valid / cfg_ready    cfg_index, cfg_data (always ready)
//
//  A step runs its taps through one shared multiplier, one product a cycle;
//  the accumulator adds each product in the next cycle, then round and saturate.
//  A steady-state preset sums the coefficients, checks the dc gains, multiplies,
//  then divides in the restoring divider, one quotient bit a cycle.
//  Reset clears the histories and loads the coefficient defaults at once.
//  A new item is taken while the previous result beat still waits; the block
//  then holds in its final state until the result register is free.
//
module direct_form_iir_filter_top import dfi_pkg::*; #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  // item channel
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [1:0]                    action,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  // result channel
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic signed [SAMPLE_BITS-1:0] filtered,
  output logic [1:0]                    status,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [COEF_W-1:0]             cfg_data
);

  localparam int PROD_W = SUM_W + SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + 3;

  localparam logic signed [COEF_W-1:0] ONE_COEF = COEF_W'(64'd1 << COEF_FRAC_BITS);
  localparam logic signed [SUM_W-1:0]  ONE_SUM  = SUM_W'(64'd1 << COEF_FRAC_BITS);
  localparam logic [SUM_W-1:0] DC_TOL = SUM_W'((64'd1 << COEF_FRAC_BITS) / 64'd1000000);

  localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] Y_MIN = ~Y_MAX;

  localparam logic [PROD_W:0] LIM_POS = (PROD_W + 1)'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [PROD_W:0] LIM_NEG = (PROD_W + 1)'(64'd1 << (SAMPLE_BITS - 1));

  // configuration registers
  logic [1:0]               filter_order;
  logic signed [COEF_W-1:0] num_coef [4];
  logic signed [COEF_W-1:0] den_coef [3];
  logic [1:0]               order;

  // filter state
  logic signed [SAMPLE_BITS-1:0] in_hist  [HIST_DEPTH];
  logic signed [SAMPLE_BITS-1:0] out_hist [HIST_DEPTH];

  // sequencer
  dfi_state_t state, state_next;
  logic [1:0] k, k_next;
  logic [1:0] k_m1;
  logic       den_term, den_term_next;

  // item held for the duration of the work
  logic [1:0]                    act_r;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic [1:0]                    st_code;

  // shared multiplier and accumulator
  logic signed [SUM_W-1:0]       mul_a;
  logic signed [SAMPLE_BITS-1:0] mul_b;
  logic signed [PROD_W-1:0]      mul_out;
  logic signed [PROD_W-1:0]      prod;
  logic                          prod_sub;
  logic                          prod_vld;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       acc_rnd;
  logic signed [ACC_W-1:0]       y_full;
  logic signed [SAMPLE_BITS-1:0] y_sat;

  // steady-state preset
  logic signed [SUM_W-1:0]       sa, sb;
  logic [SUM_W-1:0]              sa_mag, sb_mag;
  logic                          sa_zero, sb_zero;
  logic signed [SUM_W-1:0]       ratio_p, ratio_q;
  logic                          ratio_neg;
  logic [SUM_W-1:0]              q_mag;
  logic [PROD_W-1:0]             p_mag;
  logic                          div_start;
  dfi_div_stat_t                 div_stat;
  logic [PROD_W-1:0]             div_quo;
  logic [SUM_W-1:0]              div_rem;
  logic                          round_up;
  logic [PROD_W:0]               quo_r;
  logic [PROD_W:0]               quo_lim;
  logic [PROD_W:0]               quo_sat;
  logic [SAMPLE_BITS-1:0]        rat_mag;
  logic signed [SAMPLE_BITS-1:0] rat_val;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != S_IDLE);

  // cap the order at the highest supported value
  assign order = (int'(filter_order) > MAX_ORDER) ? 2'(MAX_ORDER) : filter_order;
  assign k_m1  = k - 2'd1;

  // --------------------------------------------------------------------------
  // configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_order <= 2'd0;
      num_coef[0]  <= ONE_COEF;
      num_coef[1]  <= '0;
      num_coef[2]  <= '0;
      num_coef[3]  <= '0;
      den_coef[0]  <= '0;
      den_coef[1]  <= '0;
      den_coef[2]  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FILTER_ORDER: filter_order <= cfg_data[1:0];
        REG_NUM_COEF_0:   num_coef[0]  <= cfg_data;
        REG_NUM_COEF_1:   num_coef[1]  <= cfg_data;
        REG_NUM_COEF_2:   num_coef[2]  <= cfg_data;
        REG_NUM_COEF_3:   num_coef[3]  <= cfg_data;
        REG_DEN_COEF_1:   den_coef[0]  <= cfg_data;
        REG_DEN_COEF_2:   den_coef[1]  <= cfg_data;
        REG_DEN_COEF_3:   den_coef[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      k        <= 2'd0;
      den_term <= 1'b0;
    end else begin
      state    <= state_next;
      k        <= k_next;
      den_term <= den_term_next;
    end
  end

  always_comb begin
    state_next    = state;
    k_next        = k;
    den_term_next = den_term;
    div_start     = 1'b0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          k_next        = 2'd0;
          den_term_next = 1'b0;
          case (action)
            ACT_STEP:                    state_next = S_MAC;
            ACT_RESET_IN, ACT_RESET_OUT: state_next = S_SUM;
            default:                     state_next = S_DONE;
          endcase
        end
      end
      S_MAC: begin
        // numerator term first, then the denominator term of the same tap
        if (k == order && (k == 2'd0 || den_term)) begin
          state_next = S_MAC_TAIL;
        end else if (!den_term && k != 2'd0) begin
          den_term_next = 1'b1;
        end else begin
          k_next        = k + 2'd1;
          den_term_next = 1'b0;
        end
      end
      S_MAC_TAIL: state_next = S_ROUND;
      S_ROUND:    state_next = S_DONE;
      S_SUM: begin
        if (k == order) begin
          state_next = S_CHECK;
        end else begin
          k_next = k + 2'd1;
        end
      end
      S_CHECK: begin
        if (sa_zero || (act_r == ACT_RESET_OUT && sb_zero)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_RMUL;
        end
      end
      S_RMUL:  state_next = S_DIVGO;
      S_DIVGO: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_next = S_RFILL;
        end
      end
      S_RFILL: state_next = S_DONE;
      S_DONE: begin
        if (!result_valid || !result_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // shared multiplier: coefficient times sample, or dc gain sum times level
  // --------------------------------------------------------------------------
  always_comb begin
    if (state == S_RMUL) begin
      mul_a = ratio_p;
      mul_b = x_r;
    end else if (den_term) begin
      mul_a = SUM_W'(den_coef[k_m1]);
      mul_b = out_hist[k_m1];
    end else begin
      mul_a = SUM_W'(num_coef[k]);
      mul_b = (k == 2'd0) ? x_r : in_hist[k_m1];
    end
  end

  assign mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= (state == S_MAC);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MAC || state == S_RMUL) begin
      prod     <= mul_out;
      prod_sub <= den_term;
    end
    if (state == S_IDLE) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= prod_sub ? acc - ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  // round half up at the binary point, then saturate
  assign acc_rnd = acc + HALF;
  assign y_full  = acc_rnd >>> COEF_FRAC_BITS;
  assign y_sat   = (y_full > Y_MAX) ? Y_MAX[SAMPLE_BITS-1:0] :
                   (y_full < Y_MIN) ? Y_MIN[SAMPLE_BITS-1:0] :
                   y_full[SAMPLE_BITS-1:0];

  // --------------------------------------------------------------------------
  // steady-state preset: x * p / q
  // --------------------------------------------------------------------------
  assign sa_mag  = sa[SUM_W-1] ? SUM_W'(-sa) : SUM_W'(sa);
  assign sb_mag  = sb[SUM_W-1] ? SUM_W'(-sb) : SUM_W'(sb);
  assign sa_zero = (sa_mag <= DC_TOL);
  assign sb_zero = (sb_mag <= DC_TOL);

  assign q_mag = ratio_q[SUM_W-1] ? SUM_W'(-ratio_q) : SUM_W'(ratio_q);
  assign p_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      sa <= ONE_SUM;
      sb <= '0;
    end else if (state == S_SUM) begin
      sb <= sb + SUM_W'(num_coef[k]);
      if (k != 2'd0) begin
        sa <= sa + SUM_W'(den_coef[k_m1]);
      end
    end
    if (state == S_CHECK) begin
      ratio_p <= (act_r == ACT_RESET_IN) ? sb : sa;
      ratio_q <= (act_r == ACT_RESET_IN) ? sa : sb;
    end
    if (state == S_DIVGO) begin
      ratio_neg <= prod[PROD_W-1] ^ ratio_q[SUM_W-1];
    end
  end

  dfi_div #(
    .NUM_W (PROD_W),
    .DEN_W (SUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (p_mag),
    .den   (q_mag),
    .stat  (div_stat),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // round half away from zero on the magnitude, then saturate
  assign round_up = ({div_rem, 1'b0} >= {1'b0, q_mag});
  assign quo_r    = {1'b0, div_quo} + (PROD_W + 1)'(round_up);
  assign quo_lim  = ratio_neg ? LIM_NEG : LIM_POS;
  assign quo_sat  = (quo_r > quo_lim) ? quo_lim : quo_r;
  assign rat_mag  = quo_sat[SAMPLE_BITS-1:0];
  assign rat_val  = ratio_neg ? -rat_mag : rat_mag;

  // --------------------------------------------------------------------------
  // item capture and status
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      act_r   <= action;
      x_r     <= sample;
      st_code <= ST_OK;
    end else if (state == S_CHECK) begin
      if (sa_zero) begin
        st_code <= ST_INF_GAIN;
      end else if (act_r == ACT_RESET_OUT && sb_zero) begin
        st_code <= ST_ZERO_GAIN;
      end
    end
  end

  // --------------------------------------------------------------------------
  // histories: shift on a step, fill on a preset, clear on a dc fault
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        in_hist[i]  <= '0;
        out_hist[i] <= '0;
      end
    end else begin
      case (state)
        S_ROUND: begin
          for (int i = HIST_DEPTH - 1; i > 0; i--) begin
            in_hist[i]  <= in_hist[i-1];
            out_hist[i] <= out_hist[i-1];
          end
          in_hist[0]  <= x_r;
          out_hist[0] <= y_sat;
        end
        S_CHECK: begin
          if (sa_zero || (act_r == ACT_RESET_OUT && sb_zero)) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
              in_hist[i]  <= '0;
              out_hist[i] <= '0;
            end
          end
        end
        S_RFILL: begin
          for (int i = 0; i < HIST_DEPTH; i++) begin
            in_hist[i]  <= (act_r == ACT_RESET_IN) ? x_r : rat_val;
            out_hist[i] <= (act_r == ACT_RESET_IN) ? rat_val : x_r;
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // result register: hold the beat until taken
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_DONE && (!result_valid || !result_stall)) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!result_valid || !result_stall)) begin
      filtered <= out_hist[0];
      status   <= st_code;
    end
  end

endmodule

/* rtl/core/dfi_chk.sv */
// ----------------------------------------------------------------------------
// dfi_chk: port checker of the direct-form IIR filter
// Watches the item and result channels; bound to the top level below.
// ----------------------------------------------------------------------------
module dfi_chk import dfi_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_stall,
  input logic                          result_valid,
  input logic                          result_stall,
  input logic signed [SAMPLE_BITS-1:0] filtered,
  input logic [1:0]                    status
);

  // reset leaves the block empty and ready for an item
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("block not idle after reset");

  // one item at a time: an accepted beat closes the item channel
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item channel open straight after a beat");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(filtered) && $stable(status))
    else $error("stalled result beat changed");

  // a dc gain fault clears the histories, so the result reads zero
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_OK |-> filtered == '0)
    else $error("fault result with non-zero output");

endmodule

bind direct_form_iir_filter_top dfi_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_chk (.*);

/* tb/tb_direct_form_iir_filter_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_direct_form_iir_filter_top: self-checking bench for the direct-form IIR
// Drives filter steps and level presets through the item channel and programs
// the coefficients through the register port. A cycle-free copy of the filter
// predicts each result, and the results are compared beat by beat.
// ----------------------------------------------------------------------------
module tb_direct_form_iir_filter_top import dfi_pkg::*;;

  localparam int SMP_W           = 24;
  localparam int FRAC_W          = 24;
  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 8;
  localparam int SETTLE_CYCLES   = 80;     // longer than the slowest preset
  localparam int HOLD_CYCLES     = 400;    // long receiver hold-off
  localparam int N_PHASES        = 8;
  localparam int PHASE_ITEMS     = 220;
  localparam int DRAIN_LIMIT     = 200000;
  localparam longint WATCHDOG_CYCLES = 1000000;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam longint ONE      = 64'sd1 <<< FRAC_W;
  localparam longint HALF_LSB = 64'sd1 <<< (FRAC_W - 1);
  localparam longint DC_TOL   = ONE / 1000000;
  localparam longint SMP_MAX  = (64'sd1 <<< (SMP_W - 1)) - 1;
  localparam longint SMP_MIN  = -SMP_MAX - 1;
  localparam longint COEF_MAX = (64'sd1 <<< 31) - 1;
  localparam longint COEF_MIN = -COEF_MAX - 1;

  typedef struct packed {
    logic [1:0]              act;
    logic signed [SMP_W-1:0] smp;
  } filt_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] y;
    logic [1:0]              st;
  } filt_result_t;

  // block ports
  logic                    clk          = 1'b0;
  logic                    rst          = 1'b1;
  logic                    item_valid   = 1'b0;
  logic                    item_stall;
  logic [1:0]              action       = ACT_STEP;
  logic signed [SMP_W-1:0] sample       = '0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic signed [SMP_W-1:0] filtered;
  logic [1:0]              status;
  logic                    cfg_valid    = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index    = REG_FILTER_ORDER;
  logic [COEF_W-1:0]       cfg_data     = '0;

  // pacing knobs, set between phases
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        hold_go       = 1'b0;
  int unsigned hold_left     = 0;

  // beats waiting to be offered, and results still owed by the block
  filt_item_t   pending[$];
  filt_result_t owed_results[$];

  // filter image: coefficients and both history lines, newest entry first
  logic [1:0]              f_order = 2'd0;
  logic signed [COEF_W-1:0] b_coef[4] = '{32'sh0100_0000, 32'sd0, 32'sd0, 32'sd0};
  logic signed [COEF_W-1:0] a_coef[4] = '{32'sd0, 32'sd0, 32'sd0, 32'sd0};
  logic signed [SMP_W-1:0]  x_hist[3] = '{24'sd0, 24'sd0, 24'sd0};
  logic signed [SMP_W-1:0]  y_hist[3] = '{24'sd0, 24'sd0, 24'sd0};

  int errors     = 0;
  int n_results  = 0;
  int n_steps    = 0;
  int n_presets  = 0;
  int n_flagged  = 0;
  int n_unused   = 0;
  int n_settings = 0;

  direct_form_iir_filter_top #(
    .SAMPLE_BITS    (SMP_W),
    .COEF_FRAC_BITS (FRAC_W)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .filtered     (filtered),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Filter arithmetic
  // --------------------------------------------------------------------------

  // saturate to the sample width
  function automatic logic signed [SMP_W-1:0] clip(input longint v);
    if (v > SMP_MAX) return SMP_MAX[SMP_W-1:0];
    if (v < SMP_MIN) return SMP_MIN[SMP_W-1:0];
    return v[SMP_W-1:0];
  endfunction

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // x * p / q exactly, halves rounded away from zero, then saturated
  function automatic logic signed [SMP_W-1:0] dc_ratio(input longint x, input longint p,
                                                       input longint q);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    logic [63:0] rem;
    num = mag(x) * mag(p);
    den = mag(q);
    quo = num / den;
    rem = num % den;
    if ((rem << 1) >= den) quo = quo + 1;
    if ((x < 0) ^ (p < 0) ^ (q < 0)) return clip(-longint'(quo));
    return clip(longint'(quo));
  endfunction

  task automatic fill_hist(input logic signed [SMP_W-1:0] u, input logic signed [SMP_W-1:0] v);
    int k;
    for (k = 0; k < 3; k++) begin
      x_hist[k] = u;
      y_hist[k] = v;
    end
  endtask

  // Advance the filter image by one accepted beat and queue the result it owes.
  task automatic apply_item(input logic [1:0] act, input logic signed [SMP_W-1:0] x);
    filt_result_t r;
    longint       acc;
    longint       sa;
    longint       sb;
    int           k;
    r.st = ST_OK;
    case (act)
      ACT_STEP: begin
        acc = longint'(b_coef[0]) * longint'(x);
        for (k = 1; k <= int'(f_order); k++) begin
          acc += longint'(b_coef[k]) * longint'(x_hist[k-1]);
          acc -= longint'(a_coef[k]) * longint'(y_hist[k-1]);
        end
        for (k = 2; k > 0; k--) begin
          x_hist[k] = x_hist[k-1];
          y_hist[k] = y_hist[k-1];
        end
        x_hist[0] = x;
        // round half up at the binary point, then saturate
        y_hist[0] = clip((acc + HALF_LSB) >>> FRAC_W);
        n_steps++;
      end
      ACT_RESET_IN, ACT_RESET_OUT: begin
        sa = ONE;
        sb = 0;
        for (k = 0; k <= int'(f_order); k++) begin
          sb += longint'(b_coef[k]);
          if (k > 0) sa += longint'(a_coef[k]);
        end
        if (mag(sa) <= DC_TOL) begin
          fill_hist('0, '0);
          r.st = ST_INF_GAIN;
        end else if (act == ACT_RESET_IN) begin
          fill_hist(x, dc_ratio(x, sb, sa));
        end else if (mag(sb) <= DC_TOL) begin
          fill_hist('0, '0);
          r.st = ST_ZERO_GAIN;
        end else begin
          fill_hist(dc_ratio(x, sa, sb), x);
        end
        n_presets++;
        if (r.st != ST_OK) n_flagged++;
      end
      default: n_unused++;
    endcase
    r.y = y_hist[0];
    owed_results.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Item driver: present the next queued beat, hold it while stalled, and
  // predict its result on the edge that accepts it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : item_driver
    filt_item_t nxt;
    logic       busy;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      busy = item_valid;
      if (item_valid && !item_stall) begin
        apply_item(action, sample);
        busy = 1'b0;
      end
      // a held beat keeps its payload; a free slot may idle at random
      if (!busy) begin
        if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending.pop_front();
          action     <= nxt.act;
          sample     <= nxt.smp;
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls plus a long hold-off counted here
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    result_stall <= (hold_left > 1) || ($urandom_range(99) < stall_pct);
  end

  // --------------------------------------------------------------------------
  // Result checker: match each accepted beat against the oldest owed result
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_checker
    filt_result_t want;
    if (!rst && result_valid && !result_stall) begin
      n_results++;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, filtered %0d status %0d",
                 $time, filtered, status);
      end else begin
        want = owed_results.pop_front();
        if (filtered !== want.y) begin
          errors++;
          $display("%0t: filtered mismatch, expected %0d actual %0d",
                   $time, $signed(want.y), filtered);
        end
        if (status !== want.st) begin
          errors++;
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, want.st, status);
        end
      end
    end
  end

  // mirror register writes into the filter image
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FILTER_ORDER: f_order   <= cfg_data[1:0];
        REG_NUM_COEF_0:   b_coef[0] <= cfg_data;
        REG_NUM_COEF_1:   b_coef[1] <= cfg_data;
        REG_NUM_COEF_2:   b_coef[2] <= cfg_data;
        REG_NUM_COEF_3:   b_coef[3] <= cfg_data;
        REG_DEN_COEF_1:   a_coef[1] <= cfg_data;
        REG_DEN_COEF_2:   a_coef[2] <= cfg_data;
        REG_DEN_COEF_3:   a_coef[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic offer(input logic [1:0] act, input logic signed [SMP_W-1:0] smp);
    filt_item_t it;
    it.act = act;
    it.smp = smp;
    pending.push_back(it);
  endtask

  // wait until no beat is queued, offered or owed, then let the block settle
  task automatic wait_idle();
    do @(negedge clk);
    while (pending.size() != 0 || item_valid || owed_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_filter(input logic [1:0] ord, input longint b0, input longint b1,
                             input longint b2, input longint b3, input longint a1,
                             input longint a2, input longint a3);
    write_reg(REG_FILTER_ORDER, COEF_W'(ord));
    write_reg(REG_NUM_COEF_0, b0[COEF_W-1:0]);
    write_reg(REG_NUM_COEF_1, b1[COEF_W-1:0]);
    write_reg(REG_NUM_COEF_2, b2[COEF_W-1:0]);
    write_reg(REG_NUM_COEF_3, b3[COEF_W-1:0]);
    write_reg(REG_DEN_COEF_1, a1[COEF_W-1:0]);
    write_reg(REG_DEN_COEF_2, a2[COEF_W-1:0]);
    write_reg(REG_DEN_COEF_3, a3[COEF_W-1:0]);
    n_settings++;
  endtask

  function automatic longint spread(input longint n);
    return longint'($urandom_range(32'(2 * n))) - n;
  endfunction

  function automatic logic signed [SMP_W-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? SMP_MAX[SMP_W-1:0] : SMP_MIN[SMP_W-1:0];
      1, 2, 3: return SMP_W'($urandom());
      4, 5, 6: return SMP_W'(spread(64'sd1 <<< 16));
      default: return SMP_W'(spread(1000));
    endcase
  endfunction

  // Pick a coefficient set of the given flavour and program it.
  task automatic choose_filter(input int kind);
    logic [1:0] ord;
    longint     b[4];
    longint     a[4];
    longint     r;
    int         k;
    ord = 2'($urandom_range(3));
    for (k = 0; k < 4; k++) begin
      b[k] = spread(ONE);
      a[k] = spread(ONE >>> 2);
    end
    case (kind)
      0: ;  // modest taps, well-behaved recursion
      1: begin
        // one-pole low-pass with unity dc gain; upper taps are ignored
        ord  = 2'd1;
        r    = longint'($urandom_range(1 << 23, 1));
        b[0] = r;
        b[1] = 0;
        a[1] = r - ONE;
        b[2] = spread(64'sd1 <<< 30);
        a[3] = spread(64'sd1 <<< 30);
      end
      2: begin
        for (k = 0; k < 4; k++) begin
          b[k] = longint'($signed($urandom()));
          a[k] = longint'($signed($urandom()));
        end
      end
      3: begin
        // steer sum(a) and/or sum(b) into the near-zero band and its edges
        ord = 2'($urandom_range(3, 1));
        if ($urandom_range(2) != 0) begin
          a[ord] = spread(20) - ONE;
          for (k = 1; k < int'(ord); k++) a[ord] -= a[k];
        end
        if ($urandom_range(2) != 0) begin
          b[ord] = spread(20);
          for (k = 0; k < int'(ord); k++) b[ord] -= b[k];
        end
      end
      default: begin
        ord = 2'd3;
        for (k = 0; k < 8; k++) begin
          case ($urandom_range(4))
            0:       r = COEF_MIN;
            1:       r = COEF_MAX;
            2:       r = 0;
            3:       r = ONE;
            default: r = -ONE;
          endcase
          if (k < 4) b[k] = r;
          else a[k-4] = r;
        end
      end
    endcase
    load_filter(ord, b[0], b[1], b[2], b[3], a[1], a[2], a[3]);
  endtask

  // Mostly presets followed by step runs, some bare step runs, a little noise.
  task automatic gen_phase(input int n);
    int                      made;
    int                      len;
    int                      i;
    int                      pick;
    logic                    steady;
    logic [1:0]              act;
    logic signed [SMP_W-1:0] lvl;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        lvl    = rand_sample();
        steady = 1'($urandom_range(1));
        offer($urandom_range(1) ? ACT_RESET_IN : ACT_RESET_OUT, lvl);
        len = $urandom_range(20, 4);
        for (i = 0; i < len; i++) offer(ACT_STEP, steady ? lvl : rand_sample());
        made += len + 1;
      end else if (pick < 92) begin
        len = $urandom_range(12, 1);
        for (i = 0; i < len; i++) offer(ACT_STEP, rand_sample());
        made += len;
      end else begin
        act = 2'($urandom_range(3));
        offer(act, rand_sample());
        if (act != ACT_UNUSED) made++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int p;
    int w;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // defaults after reset: pass-through of order zero
    offer(ACT_STEP, SMP_MAX[SMP_W-1:0]);
    offer(ACT_STEP, SMP_MIN[SMP_W-1:0]);
    offer(ACT_STEP, 24'sd0);
    offer(ACT_STEP, -24'sd1);
    offer(ACT_RESET_IN, 24'sd1234);
    offer(ACT_RESET_OUT, -24'sd4321);
    offer(ACT_UNUSED, SMP_MAX[SMP_W-1:0]);
    wait_idle();

    // extreme coefficients: saturation both ways; sum(b) lands in the zero band
    load_filter(2'd3, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MIN);
    offer(ACT_STEP, SMP_MAX[SMP_W-1:0]);
    offer(ACT_STEP, SMP_MIN[SMP_W-1:0]);
    offer(ACT_STEP, SMP_MIN[SMP_W-1:0]);
    offer(ACT_STEP, SMP_MAX[SMP_W-1:0]);
    offer(ACT_RESET_IN, SMP_MIN[SMP_W-1:0]);
    offer(ACT_RESET_OUT, SMP_MAX[SMP_W-1:0]);
    wait_idle();

    // pole at dc: both presets must flag infinite gain
    load_filter(2'd1, ONE, 0, 0, 0, -ONE, 0, 0);
    offer(ACT_RESET_IN, 24'sd100);
    offer(ACT_RESET_OUT, 24'sd100);
    offer(ACT_STEP, 24'sd5);
    wait_idle();

    // sum(a) right on the tolerance edge still counts as zero
    load_filter(2'd1, 8, -24, 0, 0, 16 - ONE, 0, 0);
    offer(ACT_RESET_IN, 24'sd7);
    wait_idle();

    // one step past the edge: valid but tiny sums
    load_filter(2'd1, 8, -25, 0, 0, 17 - ONE, 0, 0);
    offer(ACT_RESET_IN, 24'sd1000);
    offer(ACT_RESET_OUT, 24'sd3);
    offer(ACT_STEP, SMP_MIN[SMP_W-1:0]);
    wait_idle();

    // zero dc gain on output preset; exact halves in both rounding modes
    load_filter(2'd0, 16, 0, 0, 0, 0, 0, 0);
    offer(ACT_RESET_OUT, 24'sd5);
    offer(ACT_RESET_IN, 24'sd524288);
    offer(ACT_RESET_IN, -24'sd524288);
    offer(ACT_STEP, -24'sd524288);
    wait_idle();

    // random phases, each with its own coefficients and pacing
    for (p = 0; p < N_PHASES; p++) begin
      if (p != 0) wait_idle();
      choose_filter(p % 5);
      @(posedge clk);
      case (p % 4)
        0: begin
          send_idle_pct <= 0;
          stall_pct     <= 0;
        end
        1: begin
          send_idle_pct <= 74;
          stall_pct     <= 0;
        end
        2: begin
          send_idle_pct <= 0;
          stall_pct     <= 74;
        end
        default: begin
          send_idle_pct <= 10;
          stall_pct     <= 10;
        end
      endcase
      // hold the receiver off while the sender keeps offering
      if (p % 4 == 0) begin
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      @(negedge clk);
      gen_phase(PHASE_ITEMS);
    end

    // drain with a bound so a lost result is reported rather than waited on
    for (w = 0; w < DRAIN_LIMIT &&
         (pending.size() != 0 || item_valid || owed_results.size() != 0); w++)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (owed_results.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, owed_results.size());
    $display("Checked %0d results: %0d steps, %0d level presets (%0d flagged), %0d unused",
             n_results, n_steps, n_presets, n_flagged, n_unused);
    $display("Covered %0d coefficient settings incl. extreme and near-singular sets",
             n_settings);
    if (errors == 0 && owed_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog: stop a hung run
  initial begin : watchdog
    #(longint'(2 * HALF_PERIOD) * WATCHDOG_CYCLES);
    $display("%0t: timed out with %0d results owed", $time, owed_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* direct_form_iir_filter_top.f */
rtl/core/dfi_pkg.sv
rtl/core/dfi_div.sv
rtl/core/direct_form_iir_filter_top.sv
rtl/core/dfi_chk.sv
tb/tb_direct_form_iir_filter_top.sv
